// ----- rtl/assert_macros.svh -----
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clk edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clk edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/ahdlc_pkg.sv -----
package ahdlc_pkg;

  localparam logic [7:0]  FLAG_BYTE = 8'h7E;
  localparam logic [7:0]  ESC_BYTE  = 8'h7D;
  localparam logic [7:0]  ESC_XOR   = 8'h20;
  localparam logic [15:0] FCS_POLY  = 16'h8408;
  localparam logic [15:0] FCS_INIT  = 16'hFFFF;
  localparam logic [15:0] FCS_GOOD  = 16'hF0B8;

  localparam int unsigned LEN_W = 12;
  localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

  localparam logic [LEN_W-1:0] MIN_FRAME_RST = 12'd4;
  localparam logic [LEN_W-1:0] MAX_FRAME_RST = 12'd2048;

  typedef enum logic [0:0] {
    CFG_MIN_FRAME = 1'b0,
    CFG_MAX_FRAME = 1'b1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_RECV = 2'd1,
    PH_ESC  = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_FCS   = 3'd1,
    ST_SHORT = 3'd2,
    ST_LONG  = 3'd3,
    ST_ABORT = 3'd4
  } status_t;

  typedef enum logic [0:0] {
    KIND_DATA = 1'b0,
    KIND_END  = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t            kind;
    logic [7:0]       data;
    status_t          status;
    logic [LEN_W-1:0] length;
  } result_t;

endpackage

// ----- rtl/ahdlc_crc16.sv -----
module ahdlc_crc16 (
  input  logic [15:0] crc_in,
  input  logic [7:0]  data_in,
  output logic [15:0] crc_out
);
  import ahdlc_pkg::*;

  // reflected CRC, one bit per step, LSB first
  always_comb begin
    logic [15:0] c;
    c = crc_in ^ {8'h00, data_in};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ FCS_POLY;
      end else begin
        c = c >> 1;
      end
    end
    crc_out = c;
  end

endmodule

// ----- rtl/ahdlc_unstuff.sv -----
module ahdlc_unstuff (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    fire,
  input  logic [7:0]              rx_byte,
  input  logic [ahdlc_pkg::LEN_W-1:0] min_len,
  input  logic [ahdlc_pkg::LEN_W-1:0] lim_len,
  output logic                    has_res,
  output ahdlc_pkg::result_t      res
);
  import ahdlc_pkg::*;

  phase_t           phase_r, phase_nxt;
  logic [LEN_W-1:0] count_r, count_nxt;
  logic [15:0]      fcs_r, fcs_nxt;

  logic [7:0]  data_byte;
  logic [15:0] fcs_upd;

  assign data_byte = (phase_r == PH_ESC) ? (rx_byte ^ ESC_XOR) : rx_byte;

  ahdlc_crc16 u_crc (
    .crc_in  (fcs_r),
    .data_in (data_byte),
    .crc_out (fcs_upd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      count_r <= '0;
      fcs_r   <= FCS_INIT;
    end else if (fire) begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
      fcs_r   <= fcs_nxt;
    end
  end

  always_comb begin
    logic take;
    logic [2:0] end_st;
    logic is_end;
    phase_nxt = phase_r;
    count_nxt = count_r;
    fcs_nxt   = fcs_r;
    take      = 1'b0;
    is_end    = 1'b0;
    end_st    = ST_OK;
    has_res   = 1'b0;
    res       = '0;

    unique case (phase_r)
      PH_RECV: begin
        if (rx_byte == ESC_BYTE) begin
          phase_nxt = PH_ESC;
        end else if (rx_byte == FLAG_BYTE) begin
          is_end = 1'b1;
          if (count_r < min_len) begin
            end_st = ST_SHORT;
          end else if (fcs_r == FCS_GOOD) begin
            end_st = ST_OK;
          end else begin
            end_st = ST_FCS;
          end
        end else begin
          take = 1'b1;
        end
      end
      PH_ESC: begin
        if (rx_byte == FLAG_BYTE) begin
          is_end = 1'b1;
          end_st = ST_ABORT;
        end else begin
          take = 1'b1;
        end
      end
      default: begin
        count_nxt = '0;
        if (rx_byte == FLAG_BYTE) begin
          phase_nxt = PH_RECV;
          fcs_nxt   = FCS_INIT;
        end else begin
          phase_nxt = PH_IDLE;
        end
      end
    endcase

    // data past the length limit closes the frame instead
    if (take && count_r >= lim_len) begin
      take   = 1'b0;
      is_end = 1'b1;
      end_st = ST_LONG;
    end

    if (take) begin
      phase_nxt  = PH_RECV;
      count_nxt  = count_r + 1'b1;
      fcs_nxt    = fcs_upd;
      has_res    = 1'b1;
      res.kind   = KIND_DATA;
      res.data   = data_byte;
      res.status = ST_OK;
      res.length = '0;
    end else if (is_end) begin
      phase_nxt  = PH_IDLE;
      has_res    = 1'b1;
      res.kind   = KIND_END;
      res.data   = '0;
      res.status = status_t'(end_st);
      res.length = count_r;
    end
  end

endmodule

// ----- rtl/async_hdlc_deframer_fcs16.sv -----
// Async HDLC receive deframer with FCS-16 check.
// Input channel: one raw line byte per word (in_valid / in_stall / in_rx_byte).
// Output channel: one word per unstuffed data byte (out_kind = 0) and one
// end-of-frame word per closing flag, abort or overlength (out_kind = 1,
// with out_frame_status and out_frame_length).
// Flags outside a frame, escape bytes and dropped idle bytes make no word.
// Config: cfg_wr_en writes cfg_wdata into min (index 0) or max (index 1)
// frame length; write only while the block is idle.
// Path: a byte is registered on accept, then decoded, CRC-updated and written
// to the output register, where its word becomes valid and waits to be taken.
// Throughput: one byte per cycle while the output word is not held, set by the
// combinational decode plus bytewise CRC update between the input and output
// registers.
// Stall: out_stall holds the output word; the input register keeps taking a
// byte that makes no word, and in_stall rises only when a byte that makes a
// word is waiting behind a held output word.
// Reset (rst_n low, synchronous): both registers empty, deframer idle,
// length limits back to 4 and 2048.
module async_hdlc_deframer_fcs16 #(
  parameter int unsigned MAX_FRAME = 2048
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [7:0]                  in_rx_byte,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_kind,
  output logic [7:0]                  out_byte,
  output logic [2:0]                  out_frame_status,
  output logic [ahdlc_pkg::LEN_W-1:0] out_frame_length,
  input  logic                        cfg_wr_en,
  input  logic [0:0]                  cfg_index,
  input  logic [ahdlc_pkg::LEN_W-1:0] cfg_wdata
);
  import ahdlc_pkg::*;

  localparam logic [LEN_W-1:0] LIM_CAP =
    (MAX_FRAME < LEN_MAX) ? LEN_W'(MAX_FRAME) : LEN_MAX;

  logic [LEN_W-1:0] min_len_r, max_len_r;
  logic [LEN_W-1:0] lim_len;

  logic       in_valid_r;
  logic [7:0] in_byte_r;

  logic    out_valid_r;
  result_t out_res_r;

  logic    has_res;
  result_t res;
  logic    out_free;
  logic    fire;

  assign lim_len  = (max_len_r < LIM_CAP) ? max_len_r : LIM_CAP;
  assign out_free = !out_valid_r || !out_stall;
  assign fire     = in_valid_r && (!has_res || out_free);
  assign in_stall = in_valid_r && !fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_len_r <= MIN_FRAME_RST;
      max_len_r <= MAX_FRAME_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_MIN_FRAME: min_len_r <= cfg_wdata;
        CFG_MAX_FRAME: max_len_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_byte_r <= in_rx_byte;
    end
  end

  ahdlc_unstuff u_unstuff (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (fire),
    .rx_byte (in_byte_r),
    .min_len (min_len_r),
    .lim_len (lim_len),
    .has_res (has_res),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= fire && has_res;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && fire && has_res) begin
      out_res_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = out_res_r.kind;
  assign out_byte         = out_res_r.data;
  assign out_frame_status = out_res_r.status;
  assign out_frame_length = out_res_r.length;

`include "assert_macros.svh"

  `ASSERT_ALWAYS(a_rst_clears_out, !rst_n |=> !out_valid, "output valid after reset")
  `ASSERT_CLK(a_data_fields_zero, out_valid && out_kind == KIND_DATA |-> out_frame_status == ST_OK && out_frame_length == '0, "data word with status or length")
  `ASSERT_CLK(a_end_byte_zero, out_valid && out_kind == KIND_END |-> out_byte == 8'h00, "end word with nonzero byte")
  `ASSERT_CLK(a_len_capped, out_valid && out_kind == KIND_END |-> out_frame_length <= LIM_CAP, "frame length above cap")

endmodule

// ----- tb/sv/async_hdlc_deframer_fcs16_tb.sv -----
module async_hdlc_deframer_fcs16_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ahdlc_pkg::*;

  localparam int unsigned FRAME_CAP = 2048;
  localparam int HOLD_CYCLES = 300;
  localparam int QUIET_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 6;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] in_rx_byte = 8'h00;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_kind;
  logic [7:0] out_byte;
  logic [2:0] out_frame_status;
  logic [LEN_W-1:0] out_frame_length;
  logic cfg_wr_en = 1'b0;
  logic [0:0] cfg_index = 1'b0;
  logic [LEN_W-1:0] cfg_wdata = '0;

  always #4 clk = ~clk;

  async_hdlc_deframer_fcs16 #(
    .MAX_FRAME(FRAME_CAP)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_rx_byte(in_rx_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_kind(out_kind),
    .out_byte(out_byte),
    .out_frame_status(out_frame_status),
    .out_frame_length(out_frame_length),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // line bytes waiting to be sent, and words the deframer owes us
  logic [7:0] line_bytes[$];
  logic [7:0] frame_bytes[$];
  result_t expected_words[$];

  // deframer state as predicted
  phase_t rx_phase = PH_IDLE;
  logic [LEN_W-1:0] rx_count = '0;
  logic [15:0] rx_fcs = FCS_INIT;
  logic [LEN_W-1:0] lim_min = MIN_FRAME_RST;
  logic [LEN_W-1:0] lim_max = MAX_FRAME_RST;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_armed = 1'b0;
  bit hold_done = 1'b0;
  int hold_left = 0;
  bit in_taken = 1'b0;
  int quiet_cycles = 0;
  int mismatch_count = 0;

  function automatic logic [15:0] fcs_next(logic [15:0] crc, logic [7:0] b);
    crc = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++)
      crc = crc[0] ? ((crc >> 1) ^ FCS_POLY) : (crc >> 1);
    return crc;
  endfunction

  function automatic bit deframe_byte(input logic [7:0] raw, output result_t res);
    logic [LEN_W-1:0] limit;
    logic [7:0] b;
    bit take;
    bit ends;
    status_t st;
    res = '0;
    limit = (lim_max < FRAME_CAP) ? lim_max : LEN_W'(FRAME_CAP);
    b = raw;
    take = 1'b0;
    ends = 1'b0;
    st = ST_OK;
    if (rx_phase == PH_RECV) begin
      if (raw == ESC_BYTE) begin
        rx_phase = PH_ESC;
        return 1'b0;
      end else if (raw == FLAG_BYTE) begin
        ends = 1'b1;
        if (rx_count < lim_min) st = ST_SHORT;
        else if (rx_fcs == FCS_GOOD) st = ST_OK;
        else st = ST_FCS;
      end else begin
        take = 1'b1;
      end
    end else if (rx_phase == PH_ESC) begin
      if (raw == FLAG_BYTE) begin
        ends = 1'b1;
        st = ST_ABORT;
      end else begin
        take = 1'b1;
        b = raw ^ ESC_XOR;
      end
    end else begin
      if (raw == FLAG_BYTE) begin
        rx_phase = PH_RECV;
        rx_fcs = FCS_INIT;
      end else begin
        rx_phase = PH_IDLE;
      end
      rx_count = '0;
      return 1'b0;
    end
    if (take && rx_count >= limit) begin
      ends = 1'b1;
      st = ST_LONG;
    end
    if (ends) begin
      res.kind = KIND_END;
      res.status = st;
      res.length = rx_count;
      rx_phase = PH_IDLE;
    end else begin
      rx_fcs = fcs_next(rx_fcs, b);
      rx_count = rx_count + 1'b1;
      rx_phase = PH_RECV;
      res.kind = KIND_DATA;
      res.data = b;
      res.status = ST_OK;
    end
    return 1'b1;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    if (mismatch_count < 100)
      $display("%0t: %s: got %0h, want %0h", $time, what, got, want);
    mismatch_count++;
  endtask

  // sender: a word stays on the bus until taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (line_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_rx_byte <= line_bytes.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls plus one long hold-off to back up the pipeline
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_armed && !hold_done) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    result_t got_res;
    result_t want;
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall && deframe_byte(in_rx_byte, got_res))
        expected_words.push_back(got_res);
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          report_mismatch("word with nothing pending", out_byte, 0);
        end else begin
          want = expected_words.pop_front();
          if (out_kind !== want.kind)
            report_mismatch("kind", out_kind, want.kind);
          if (out_byte !== want.data)
            report_mismatch("byte", out_byte, want.data);
          if (out_frame_status !== want.status)
            report_mismatch("status", out_frame_status, want.status);
          if (out_frame_length !== want.length)
            report_mismatch("length", out_frame_length, want.length);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("async_hdlc_deframer_fcs16 test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(9))
      0: return FLAG_BYTE;
      1: return ESC_BYTE;
      2: return 8'h00;
      3: return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic put_escaped(logic [7:0] b, bit force_esc);
    if (b == FLAG_BYTE || b == ESC_BYTE || force_esc) begin
      line_bytes.push_back(ESC_BYTE);
      line_bytes.push_back(b ^ ESC_XOR);
    end else begin
      line_bytes.push_back(b);
    end
  endtask

  // frame_bytes holds the payload; FCS is appended, then the whole is stuffed
  task automatic queue_frame(bit corrupt, int esc_pct);
    logic [15:0] crc;
    int k;
    crc = FCS_INIT;
    foreach (frame_bytes[i]) crc = fcs_next(crc, frame_bytes[i]);
    crc = ~crc;
    frame_bytes.push_back(crc[7:0]);
    frame_bytes.push_back(crc[15:8]);
    if (corrupt) begin
      k = $urandom_range(frame_bytes.size() - 1);
      frame_bytes[k][$urandom_range(7)] ^= 1'b1;
    end
    line_bytes.push_back(FLAG_BYTE);
    foreach (frame_bytes[i]) put_escaped(frame_bytes[i], $urandom_range(99) < esc_pct);
    line_bytes.push_back(FLAG_BYTE);
    frame_bytes.delete();
  endtask

  task automatic queue_random_frame(int max_len);
    int n;
    int pick;
    n = ($urandom_range(7) == 0) ? $urandom_range(max_len)
                                 : $urandom_range(max_len < 8 ? max_len : 8);
    pick = $urandom_range(99);
    if (pick < 74) begin
      repeat (n) frame_bytes.push_back(pick_byte());
      queue_frame(pick >= 62, 10);
    end else if (pick < 82) begin
      // abort: escape directly before a flag
      line_bytes.push_back(FLAG_BYTE);
      repeat (n) put_escaped(pick_byte(), $urandom_range(9) == 0);
      line_bytes.push_back(ESC_BYTE);
      line_bytes.push_back(FLAG_BYTE);
    end else if (pick < 90) begin
      repeat (1 + n % 6) line_bytes.push_back(pick_byte());
    end else begin
      // unstuffed junk between flags
      line_bytes.push_back(FLAG_BYTE);
      repeat (n) line_bytes.push_back(pick_byte());
      line_bytes.push_back(FLAG_BYTE);
    end
  endtask

  task automatic queue_random(int count, int max_len);
    int goal;
    goal = line_bytes.size() + count;
    while (line_bytes.size() < goal) queue_random_frame(max_len);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [LEN_W-1:0] val);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    if (idx == CFG_MIN_FRAME) lim_min = val;
    else lim_max = val;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    @(posedge clk);
  endtask

  task automatic run_phase(int idle_pct, int stall_pct);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    @(posedge clk);
    while (line_bytes.size() != 0 || in_valid) @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
    // escapes and idle bytes make no word but may still be in flight
    repeat (SETTLE_CYCLES) @(posedge clk);
    send_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    @(posedge clk);

    // idle junk, a frame with both reserved bytes inside, double escape,
    // abort, and an empty frame
    line_bytes.push_back(8'h00);
    line_bytes.push_back(8'hFF);
    line_bytes.push_back(ESC_BYTE);
    frame_bytes.push_back(FLAG_BYTE);
    frame_bytes.push_back(ESC_BYTE);
    frame_bytes.push_back(8'h00);
    frame_bytes.push_back(8'hFF);
    queue_frame(1'b0, 0);
    line_bytes.push_back(FLAG_BYTE);
    line_bytes.push_back(ESC_BYTE);
    line_bytes.push_back(ESC_BYTE);
    line_bytes.push_back(FLAG_BYTE);
    line_bytes.push_back(FLAG_BYTE);
    line_bytes.push_back(8'h01);
    line_bytes.push_back(ESC_BYTE);
    line_bytes.push_back(FLAG_BYTE);
    line_bytes.push_back(FLAG_BYTE);
    line_bytes.push_back(FLAG_BYTE);
    run_phase(0, 0);

    write_reg(CFG_MIN_FRAME, 12'd0);
    write_reg(CFG_MAX_FRAME, 12'd1);
    queue_random(100, 6);
    run_phase(65, 0);

    // one frame right at both limits
    write_reg(CFG_MIN_FRAME, 12'd48);
    write_reg(CFG_MAX_FRAME, 12'd48);
    repeat (46) frame_bytes.push_back(pick_byte());
    queue_frame(1'b0, 0);
    queue_random(40, 6);
    run_phase(0, 0);

    write_reg(CFG_MIN_FRAME, 12'd3);
    write_reg(CFG_MAX_FRAME, 12'd9);
    queue_random(120, 12);
    run_phase(27, 27);

    write_reg(CFG_MIN_FRAME, MIN_FRAME_RST);
    write_reg(CFG_MAX_FRAME, MAX_FRAME_RST);
    hold_armed = 1'b1;
    queue_random(150, 30);
    run_phase(0, 0);

    write_reg(CFG_MIN_FRAME, 12'd6);
    write_reg(CFG_MAX_FRAME, 12'd40);
    queue_random(120, 45);
    run_phase(65, 0);

    write_reg(CFG_MIN_FRAME, 12'd1);
    write_reg(CFG_MAX_FRAME, 12'd2047);
    queue_random(120, 20);
    run_phase(0, 65);

    write_reg(CFG_MIN_FRAME, 12'd0);
    write_reg(CFG_MAX_FRAME, 12'd2048);
    queue_random(110, 20);
    run_phase(27, 27);

    if (mismatch_count == 0) begin
      $display("async_hdlc_deframer_fcs16 test passed");
    end else begin
      $display("async_hdlc_deframer_fcs16 test failed");
    end
    $finish;
  end

endmodule
